[rtl/first_fit_heap_allocator_core_macros.svh]
// assertion macros for the allocator rtl
// expects clk and rst_n in the scope of every use
`ifndef FIRST_FIT_HEAP_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_CORE_MACROS_SVH

// condition holds at every edge out of reset
`define FFHA_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define FFHA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/ffha_pkg.sv]
// shared types, sizes and codes for the first-fit heap allocator
// no dependencies
`default_nettype none
package ffha_pkg;

  localparam int MAX_BLOCKS   = 64;
  localparam int HEAP_BYTES   = 4194304;
  localparam int HEADER_BYTES = 16;
  localparam int MIN_SPLIT    = 32;

  localparam int SZ_W   = 23;
  localparam int ADDR_W = 32;
  localparam int IDX_W  = $clog2(MAX_BLOCKS);
  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);

  localparam logic [SZ_W-1:0] HDR          = SZ_W'(HEADER_BYTES);
  localparam logic [SZ_W:0]   SPLIT_MARGIN = (SZ_W+1)'(MIN_SPLIT + HEADER_BYTES);

  localparam logic [ADDR_W-1:0] HEAP_BASE_RST = 32'h0010_0000;
  localparam logic [ADDR_W-1:0] TOTAL_MEM_RST = 32'h0400_0000;

  localparam logic CFG_HEAP_BASE = 1'b0;
  localparam logic CFG_TOTAL_MEM = 1'b1;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ZERO    = 2'd1;
  localparam logic [1:0] ST_NOFIT   = 2'd2;
  localparam logic [1:0] ST_BADADDR = 2'd3;

  typedef struct packed {
    logic [SZ_W-1:0] offset;
    logic [SZ_W-1:0] size;
    logic            free;
  } entry_t;

  localparam entry_t ENTRY_FIRST = '{offset: '0, size: SZ_W'(HEAP_BYTES - HEADER_BYTES),
                                     free: 1'b1};

endpackage
`default_nettype wire

[rtl/ffha_cell.sv]
// one slot of the block table chain: holds an entry, takes the right neighbor's on shift
// depends on ffha_pkg
`default_nettype none
module ffha_cell (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            shift_en,
  input  wire ffha_pkg::entry_t init,
  input  wire ffha_pkg::entry_t d_in,
  output ffha_pkg::entry_t     q
);
  import ffha_pkg::*;

  entry_t q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= init;
    end else if (shift_en) begin
      q_r <= d_in;
    end
  end

  assign q = q_r;

endmodule
`default_nettype wire

[rtl/ffha_ctrl.sv]
// sequencer of the allocator: scan pass, edit pass, result beat, config registers
// depends on ffha_pkg and the macros header
`default_nettype none
`include "first_fit_heap_allocator_core_macros.svh"
module ffha_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         in_op,
  input  wire logic [ffha_pkg::SZ_W-1:0]    in_req_size,
  input  wire logic [ffha_pkg::ADDR_W-1:0]  in_free_address,
  output logic                              out_strobe,
  output logic [ffha_pkg::ADDR_W-1:0]       out_payload_address,
  output logic [1:0]                        out_status,
  output logic [ffha_pkg::SZ_W-1:0]         out_used_bytes,
  output logic [ffha_pkg::ADDR_W-1:0]       out_free_bytes,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_index,
  input  wire logic [ffha_pkg::ADDR_W-1:0]  cfg_wdata,
  output logic                              shift_en,
  output ffha_pkg::entry_t                  tail,
  input  wire ffha_pkg::entry_t             head,
  input  wire ffha_pkg::entry_t             next1,
  input  wire ffha_pkg::entry_t             next2
);
  import ffha_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EDIT = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [IDX_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  blk_count_r;
  logic [SZ_W-1:0]   used_r;
  logic [ADDR_W-1:0] base_r, total_r;

  logic              op_r;
  logic [SZ_W-1:0]   req_r;
  logic [ADDR_W-1:0] addr_r;
  logic              found_r, split_r, prev_free_r;
  logic [SZ_W-1:0]   prev_size_r, msize_r, gsize_r;
  logic [IDX_W-1:0]  idx_r, p_r;
  logic [1:0]        k_r;
  logic [1:0]        status_r;
  logic [ADDR_W-1:0] res_addr_r;
  entry_t            hold_r;

  logic              out_strobe_r;
  logic [ADDR_W-1:0] out_addr_r, out_free_r;
  logic [1:0]        out_status_r;
  logic [SZ_W-1:0]   out_used_r;

  logic              last, in_range, next_ok, pf, nf;
  logic              alloc_hit, free_hit, hit, can_split;
  logic [ADDR_W-1:0] payload;
  logic [SZ_W-1:0]   msize, used_new, amount;
  logic [CNT_W-1:0]  t_w;
  entry_t            emit;

  assign last     = (cnt_r == IDX_W'(MAX_BLOCKS - 1));
  assign t_w      = CNT_W'(cnt_r);
  assign in_range = t_w < blk_count_r;
  assign next_ok  = (t_w + CNT_W'(1)) < blk_count_r;
  assign payload  = base_r + ADDR_W'(head.offset) + ADDR_W'(HEADER_BYTES);
  assign pf       = prev_free_r;
  assign nf       = next_ok && next1.free;

  assign alloc_hit = (op_r == OP_ALLOC) && !found_r && in_range && head.free &&
                     (head.size >= req_r);
  assign free_hit  = (op_r == OP_FREE) && !found_r && in_range && !head.free &&
                     (payload == addr_r);
  assign hit       = alloc_hit || free_hit;
  assign can_split = ({1'b0, head.size} > ({1'b0, req_r} + SPLIT_MARGIN)) &&
                     (blk_count_r < CNT_W'(MAX_BLOCKS));
  // freed block plus whichever neighbors are free
  assign msize = head.size + (pf ? prev_size_r + HDR : '0) + (nf ? next1.size + HDR : '0);

  assign amount = gsize_r + HDR;
  always_comb begin
    if (op_r == OP_ALLOC) begin
      used_new = used_r + amount;
    end else begin
      used_new = (used_r >= amount) ? used_r - amount : '0;
    end
  end

  // entry written to the tail during the edit pass
  always_comb begin
    emit = head;
    if (op_r == OP_ALLOC) begin
      if (cnt_r == idx_r) begin
        emit.size = split_r ? req_r : head.size;
        emit.free = 1'b0;
      end else if (split_r && ({1'b0, cnt_r} == ({1'b0, idx_r} + (IDX_W+1)'(1)))) begin
        emit.offset = hold_r.offset + HDR + req_r;
        emit.size   = hold_r.size - req_r - HDR;
        emit.free   = 1'b1;
      end else if (split_r && (cnt_r > idx_r)) begin
        emit = hold_r;
      end
    end else begin
      if (cnt_r == p_r) begin
        emit.size = msize_r;
        emit.free = 1'b1;
      end else if (cnt_r > p_r) begin
        if ((t_w + CNT_W'(k_r)) >= blk_count_r) begin
          emit = '0;
        end else begin
          unique case (k_r)
            2'd1:    emit = next1;
            2'd2:    emit = next2;
            default: emit = head;
          endcase
        end
      end
    end
  end

  assign shift_en = (state_r == S_SCAN) || (state_r == S_EDIT);
  assign tail     = (state_r == S_SCAN) ? head : emit;
  assign busy     = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = ((in_op == OP_ALLOC) && (in_req_size == '0)) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (last) begin
          state_nxt = (found_r || hit) ? S_EDIT : S_DONE;
        end
      end
      S_EDIT: begin
        if (last) begin
          state_nxt = S_DONE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      blk_count_r  <= CNT_W'(1);
      used_r       <= '0;
      base_r       <= HEAP_BASE_RST;
      total_r      <= TOTAL_MEM_RST;
      found_r      <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= (state_r == S_DONE);
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_HEAP_BASE: base_r  <= cfg_wdata;
          default:       total_r <= cfg_wdata;
        endcase
      end
      if (state_r == S_IDLE) begin
        cnt_r   <= '0;
        found_r <= 1'b0;
      end else if (shift_en) begin
        cnt_r <= cnt_r + IDX_W'(1);
        if (hit && (state_r == S_SCAN)) begin
          found_r <= 1'b1;
        end
      end
      if ((state_r == S_EDIT) && last) begin
        used_r <= used_new;
        if (op_r == OP_ALLOC) begin
          blk_count_r <= blk_count_r + CNT_W'(split_r);
        end else begin
          blk_count_r <= blk_count_r - CNT_W'(k_r);
        end
      end
    end
  end

  // request and scan payload
  always_ff @(posedge clk) begin
    if ((state_r == S_IDLE) && start) begin
      op_r        <= in_op;
      req_r       <= in_req_size;
      addr_r      <= in_free_address;
      res_addr_r  <= '0;
      prev_free_r <= 1'b0;
      status_r    <= ST_ZERO;
    end
    if (state_r == S_SCAN) begin
      prev_free_r <= head.free;
      prev_size_r <= head.size;
      if (hit) begin
        idx_r   <= cnt_r;
        split_r <= can_split;
        gsize_r <= (alloc_hit && !can_split) || free_hit ? head.size : req_r;
        msize_r <= msize;
        p_r     <= pf ? cnt_r - IDX_W'(1) : cnt_r;
        k_r     <= {pf & nf, pf ^ nf};
        if (alloc_hit) begin
          res_addr_r <= payload;
        end
      end
      if (last) begin
        if (found_r || hit) begin
          status_r <= ST_OK;
        end else begin
          status_r <= (op_r == OP_ALLOC) ? ST_NOFIT : ST_BADADDR;
        end
      end
    end
    if (state_r == S_EDIT) begin
      hold_r <= head;
    end
    if (state_r == S_DONE) begin
      out_addr_r   <= res_addr_r;
      out_status_r <= status_r;
      out_used_r   <= used_r;
      out_free_r   <= (total_r > ADDR_W'(used_r)) ? total_r - ADDR_W'(used_r) : '0;
    end
  end

  assign out_strobe          = out_strobe_r;
  assign out_payload_address = out_addr_r;
  assign out_status          = out_status_r;
  assign out_used_bytes      = out_used_r;
  assign out_free_bytes      = out_free_r;

  `FFHA_ASSERT_ALWAYS(a_count_range, (blk_count_r >= CNT_W'(1)) && (blk_count_r <= CNT_W'(MAX_BLOCKS)), "block count out of range")
  `FFHA_ASSERT_IMPL(a_strobe_from_done, out_strobe_r, $past(state_r) == S_DONE, "result beat without done state")
  `FFHA_ASSERT_IMPL(a_edit_has_hit, state_r == S_EDIT, found_r, "edit pass without a target block")
  `FFHA_ASSERT_IMPL(a_fail_no_addr, out_strobe_r && (out_status_r != ST_OK), out_addr_r == '0, "failed request returned an address")

endmodule
`default_nettype wire

[rtl/first_fit_heap_allocator_core.sv]
// First-fit heap allocator: a request starts on start while busy is low,
// with in_op (allocate or free), in_req_size and in_free_address.
// The block table is a chain of 64 cells that rotates one slot per cycle
// through the sequencer during the scan and edit passes. A request takes
// a scan pass over all 64 cells, then an edit pass when it changes the
// table (split, mark or merge), then a done state that forms the result;
// a zero-size allocate skips both passes. busy stays high until the
// result cycle, so one request is in flight at a time.
// The result beat sits on the out_ ports for exactly one cycle with
// out_strobe high; the receiver cannot stall, and start may be raised in
// that same cycle.
// Config registers (heap base, total memory) are written through cfg_we,
// cfg_index and cfg_wdata at any edge; they are meant to change only
// while busy is low.
// Reset (rst_n low at a clock edge) restores one free block covering the
// heap, zero bytes used and the default config values.
// depends on ffha_pkg, ffha_cell, ffha_ctrl
`default_nettype none
module first_fit_heap_allocator_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         in_op,
  input  wire logic [ffha_pkg::SZ_W-1:0]    in_req_size,
  input  wire logic [ffha_pkg::ADDR_W-1:0]  in_free_address,
  output logic                              out_strobe,
  output logic [ffha_pkg::ADDR_W-1:0]       out_payload_address,
  output logic [1:0]                        out_status,
  output logic [ffha_pkg::SZ_W-1:0]         out_used_bytes,
  output logic [ffha_pkg::ADDR_W-1:0]       out_free_bytes,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_index,
  input  wire logic [ffha_pkg::ADDR_W-1:0]  cfg_wdata
);
  import ffha_pkg::*;

  entry_t cell_q [MAX_BLOCKS];
  entry_t tail;
  logic   shift_en;

  for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
    entry_t init_k, d_k;
    if (k == 0) begin : g_first
      assign init_k = ENTRY_FIRST;
    end else begin : g_rest
      assign init_k = '0;
    end
    if (k == MAX_BLOCKS - 1) begin : g_tail
      assign d_k = tail;
    end else begin : g_mid
      assign d_k = cell_q[k+1];
    end
    ffha_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .init     (init_k),
      .d_in     (d_k),
      .q        (cell_q[k])
    );
  end

  ffha_ctrl u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_op               (in_op),
    .in_req_size         (in_req_size),
    .in_free_address     (in_free_address),
    .out_strobe          (out_strobe),
    .out_payload_address (out_payload_address),
    .out_status          (out_status),
    .out_used_bytes      (out_used_bytes),
    .out_free_bytes      (out_free_bytes),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .shift_en            (shift_en),
    .tail                (tail),
    .head                (cell_q[0]),
    .next1               (cell_q[1]),
    .next2               (cell_q[2])
  );

endmodule
`default_nettype wire
